// ===== rtl/core/qdot_pkg.sv =====
// Package for the quantized int8/int4 dot product block.
// Holds the sequencer state type, datapath widths and fixed constants.
// No dependencies.
`default_nettype none

package qdot_pkg;

	localparam int WPAIR_W  = 16;
	localparam int ACT_W    = 8;
	localparam int SCALE_W  = 24;
	localparam int BIAS_W   = 32;
	localparam int GSUM_W   = 29;
	localparam int ACC_W    = 48;
	localparam int MUL_A_W  = 30;
	localparam int MUL_B_W  = 25;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
	localparam int HALF_W   = 24;
	localparam int PROD_W   = ACC_W + SCALE_W;
	localparam int Q_W      = 51;

	localparam logic [7:0]       NIB_MASK   = 8'h0F;
	localparam int               NIB_SHIFT  = 4;
	localparam logic signed [8:0] NIB_OFFSET = 9'sd8;

	localparam logic signed [GSUM_W-1:0] GSUM_MAX = {1'b0, {(GSUM_W-1){1'b1}}};
	localparam logic signed [GSUM_W-1:0] GSUM_MIN = {1'b1, {(GSUM_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [Q_W-1:0]           Q_CAP    = {1'b1, {(Q_W-1){1'b0}}};

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_PROD0 = 9'b000000010,
		S_PROD1 = 9'b000000100,
		S_GROUP = 9'b000001000,
		S_MAG   = 9'b000010000,
		S_LO    = 9'b000100000,
		S_HI    = 9'b001000000,
		S_RND   = 9'b010000000,
		S_OUT   = 9'b100000000
	} qdot_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/qdot_req_if.sv =====
// Request channel interface: valid/ready handshake with one weight pair,
// two activations, scales, bias and the group and row marks.
// Depends on qdot_pkg.
`default_nettype none

interface qdot_req_if import qdot_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [WPAIR_W-1:0]         weight_pair;
	logic signed [ACT_W-1:0]    act_even;
	logic signed [ACT_W-1:0]    act_odd;
	logic [SCALE_W-1:0]         weight_scale;
	logic [SCALE_W-1:0]         act_scale;
	logic signed [BIAS_W-1:0]   bias;
	logic                       group_end;
	logic                       row_end;

	modport source (
		output valid, weight_pair, act_even, act_odd, weight_scale, act_scale, bias,
		       group_end, row_end,
		input  ready
	);
	modport sink (
		input  valid, weight_pair, act_even, act_odd, weight_scale, act_scale, bias,
		       group_end, row_end,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/qdot_rsp_if.sv =====
// Result channel interface: valid/ready handshake with the row value
// and its saturation flag. Depends on qdot_pkg.
`default_nettype none

interface qdot_rsp_if import qdot_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [ACC_W-1:0]   row_value;
	logic                      saturated;

	modport source (output valid, row_value, saturated, input ready);
	modport sink (input valid, row_value, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/quantized_int8_int4_dot_product.sv =====
// Top level of the quantized int8/int4 dot product with fixed-point scaling.
// Depends on qdot_pkg, qdot_req_if, qdot_rsp_if and qdot_mul.
//
//   channel   direction  handshake      contents
//   req       in         valid/ready    weight pair, activations, scales, bias, marks
//   rsp       out        valid/ready    row value, saturated flag
//   cfg       in         write enable   weight_mode
//
// A request passes S_PROD0 and S_PROD1, then S_GROUP if it closes a group and S_MAG
// through S_OUT if it ends a row, since all products go one at a time through the
// single shared multiplier. A row result waits in the output register; a new request
// is taken while it waits, and only the next row end stalls until it is taken.
// Reset clears the sequencer, the sums, the saturation flag and weight_mode.
`default_nettype none

module quantized_int8_int4_dot_product import qdot_pkg::*; #(
	parameter int SCALE_FRACTION_BITS = 20
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	qdot_req_if.sink  req,
	qdot_rsp_if.source rsp
);

	localparam int RSUM_W = PROD_W + 1;
	localparam int GT_W   = 32;
	localparam int AS_W   = 56;
	localparam int RES_W  = Q_W + 2;
	localparam logic [RSUM_W-1:0] HALF = RSUM_W'(1) << (SCALE_FRACTION_BITS - 1);

	qdot_state_t               state_q;
	logic                      mode_q;
	logic [WPAIR_W-1:0]        wp_q;
	logic signed [ACT_W-1:0]   ae_q;
	logic signed [ACT_W-1:0]   ao_q;
	logic [SCALE_W-1:0]        wscale_q;
	logic [SCALE_W-1:0]        ascale_q;
	logic signed [BIAS_W-1:0]  bias_q;
	logic                      gend_q;
	logic                      rend_q;
	logic signed [GSUM_W-1:0]  gs_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      sat_q;
	logic signed [GT_W-1:0]    tmp_q;
	logic                      neg_q;
	logic [ACC_W-1:0]          mag_q;
	logic [PROD_W-1:0]         prod_q;
	logic [Q_W-1:0]            q_q;
	logic                      rsp_valid_q;
	logic signed [ACC_W-1:0]   row_value_q;
	logic                      saturated_q;

	logic signed [8:0]         w0;
	logic signed [8:0]         w1;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic signed [GT_W-1:0]    gsum;
	logic signed [AS_W-1:0]    asum;
	logic [RSUM_W-1:0]         rsum;
	logic [RSUM_W-1:0]         rshift;
	logic signed [RES_W-1:0]   sq;
	logic signed [RES_W-1:0]   rv;
	logic                      close_grp;
	logic                      can_load;

	always_comb begin
		if (mode_q) begin
			w0 = $signed({1'b0, wp_q[7:0] & NIB_MASK}) - NIB_OFFSET;
			w1 = $signed({1'b0, (wp_q[7:0] >> NIB_SHIFT) & NIB_MASK}) - NIB_OFFSET;
		end else begin
			w0 = 9'(signed'(wp_q[7:0]));
			w1 = 9'(signed'(wp_q[15:8]));
		end
	end

	always_comb begin
		case (state_q)
			S_PROD0: begin
				mul_a = MUL_A_W'(ae_q);
				mul_b = MUL_B_W'(w0);
			end
			S_PROD1: begin
				mul_a = MUL_A_W'(ao_q);
				mul_b = MUL_B_W'(w1);
			end
			S_GROUP: begin
				mul_a = MUL_A_W'(gs_q);
				mul_b = $signed({1'b0, wscale_q});
			end
			S_LO: begin
				mul_a = $signed({{(MUL_A_W-HALF_W){1'b0}}, mag_q[HALF_W-1:0]});
				mul_b = $signed({1'b0, ascale_q});
			end
			S_HI: begin
				mul_a = $signed({{(MUL_A_W-HALF_W){1'b0}}, mag_q[ACC_W-1:HALF_W]});
				mul_b = $signed({1'b0, ascale_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	qdot_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	always_comb begin
		gsum      = tmp_q + GT_W'(mul_p);
		asum      = AS_W'(acc_q) + AS_W'(mul_p);
		rsum      = {1'b0, prod_q} + HALF;
		rshift    = rsum >> SCALE_FRACTION_BITS;
		sq        = neg_q ? -$signed({2'b0, q_q}) : $signed({2'b0, q_q});
		rv        = sq + RES_W'(bias_q);
		close_grp = rend_q || (mode_q && gend_q);
		can_load  = !rsp_valid_q || rsp.ready;
	end

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.row_value = row_value_q;
	assign rsp.saturated = saturated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= 1'b0;
			gs_q        <= '0;
			acc_q       <= '0;
			sat_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready && !(state_q == S_OUT && can_load)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_PROD0;
					end
				end
				S_PROD0: begin
					state_q <= S_PROD1;
				end
				S_PROD1: begin
					if (gsum > GT_W'(GSUM_MAX)) begin
						gs_q  <= GSUM_MAX;
						sat_q <= 1'b1;
					end else if (gsum < GT_W'(GSUM_MIN)) begin
						gs_q  <= GSUM_MIN;
						sat_q <= 1'b1;
					end else begin
						gs_q <= GSUM_W'(gsum);
					end
					state_q <= close_grp ? S_GROUP : S_IDLE;
				end
				S_GROUP: begin
					if (asum > AS_W'(ACC_MAX)) begin
						acc_q <= ACC_MAX;
						sat_q <= 1'b1;
					end else if (asum < AS_W'(ACC_MIN)) begin
						acc_q <= ACC_MIN;
						sat_q <= 1'b1;
					end else begin
						acc_q <= ACC_W'(asum);
					end
					gs_q    <= '0;
					state_q <= rend_q ? S_MAG : S_IDLE;
				end
				S_MAG: begin
					state_q <= S_LO;
				end
				S_LO: begin
					state_q <= S_HI;
				end
				S_HI: begin
					state_q <= S_RND;
				end
				S_RND: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (can_load) begin
						rsp_valid_q <= 1'b1;
						gs_q        <= '0;
						acc_q       <= '0;
						sat_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			wp_q     <= req.weight_pair;
			ae_q     <= req.act_even;
			ao_q     <= req.act_odd;
			wscale_q <= req.weight_scale;
			ascale_q <= req.act_scale;
			bias_q   <= req.bias;
			gend_q   <= req.group_end;
			rend_q   <= req.row_end;
		end
		if (state_q == S_PROD0) begin
			tmp_q <= GT_W'(gs_q) + GT_W'(mul_p);
		end
		if (state_q == S_MAG) begin
			neg_q <= acc_q[ACC_W-1];
			mag_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		end
		if (state_q == S_LO) begin
			prod_q <= PROD_W'(mul_p[2*HALF_W-1:0]);
		end
		if (state_q == S_HI) begin
			prod_q <= prod_q + {mul_p[2*HALF_W-1:0], {HALF_W{1'b0}}};
		end
		if (state_q == S_RND) begin
			q_q <= (rshift > RSUM_W'(Q_CAP)) ? Q_CAP : Q_W'(rshift);
		end
		if (state_q == S_OUT && can_load) begin
			if (rv > RES_W'(ACC_MAX)) begin
				row_value_q <= ACC_MAX;
				saturated_q <= 1'b1;
			end else if (rv < RES_W'(ACC_MIN)) begin
				row_value_q <= ACC_MIN;
				saturated_q <= 1'b1;
			end else begin
				row_value_q <= ACC_W'(rv);
				saturated_q <= sat_q;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/qdot_mul.sv =====
// Shared signed multiplier used by every product step of the sequencer.
// Depends on qdot_pkg for operand widths.
`default_nettype none

module qdot_mul import qdot_pkg::*; (
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0]      p
);

	always_comb begin
		p = MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

`default_nettype wire

// ===== rtl/core/qdot_chk.sv =====
// Port-level checker for the dot product top level, attached by bind.
// Depends on qdot_pkg and the top level's request and result channels.
`default_nettype none

module qdot_chk import qdot_pkg::*; (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    req_valid,
	input wire logic                    req_ready,
	input wire logic                    rsp_valid,
	input wire logic                    rsp_ready,
	input wire logic signed [ACC_W-1:0] row_value,
	input wire logic                    saturated
);

	// A stalled result keeps its value and flag.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(row_value) && $stable(saturated))
		else $error("stalled result changed");

	// After a request is taken, the block stays busy through S_PROD0 and S_PROD1.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready ##1 !req_ready)
		else $error("request taken while busy");

	// A new result only appears at the end of a busy stretch.
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared while idle");

	// A result never appears in the cycle right after a request is taken.
	a_rsp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result too early after request");

endmodule

bind quantized_int8_int4_dot_product qdot_chk u_qdot_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.row_value (rsp.row_value),
	.saturated (rsp.saturated)
);

`default_nettype wire

// ===== dv/qdot_row_checker.sv =====
// Row checker for the quantized int8/int4 dot product: watches the request,
// result and register channels, predicts each row result and compares it.
// Depends on qdot_pkg, qdot_req_if and qdot_rsp_if.

module qdot_row_checker import qdot_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	qdot_req_if       req,
	qdot_rsp_if       rsp,
	output int        mismatches,
	output int        rows_pending
);

	localparam int FRAC = 20;

	typedef struct packed {
		logic signed [ACC_W-1:0] value;
		logic                    sat;
	} row_result_t;

	row_result_t expected_rows[$];
	logic        packed_mode;
	longint      group_sum;
	longint      row_acc;
	logic        sat_seen;
	int          rows_seen;

	function automatic longint clip_to(input longint v, input longint lo, input longint hi,
			output bit hit);
		hit = (v > hi) || (v < lo);
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	function automatic longint scale_row(input longint acc, input logic [SCALE_W-1:0] s);
		logic [127:0] prod;
		prod = (acc < 0) ? 128'(-acc) : 128'(acc);
		prod = prod * 128'(s) + (128'd1 << (FRAC - 1));
		prod = prod >> FRAC;
		if (prod > 128'(Q_CAP)) begin
			prod = 128'(Q_CAP);
		end
		return (acc < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	function automatic bit accumulate_pair(input logic [WPAIR_W-1:0] wp,
			input logic signed [ACT_W-1:0] ae, input logic signed [ACT_W-1:0] ao,
			input logic [SCALE_W-1:0] wscale, input logic [SCALE_W-1:0] ascale,
			input logic signed [BIAS_W-1:0] b, input logic ge, input logic re,
			output row_result_t res);
		longint w_even;
		longint w_odd;
		longint v;
		bit     hit;
		bit     clip;
		if (packed_mode) begin
			w_even = longint'(wp[3:0]) - 8;
			w_odd  = longint'(wp[7:4]) - 8;
		end else begin
			w_even = longint'(signed'(wp[7:0]));
			w_odd  = longint'(signed'(wp[15:8]));
		end
		group_sum = clip_to(group_sum + w_even * longint'(ae) + w_odd * longint'(ao),
			longint'(GSUM_MIN), longint'(GSUM_MAX), hit);
		sat_seen = sat_seen | hit;
		if (re || (packed_mode && ge)) begin
			row_acc = clip_to(row_acc + group_sum * longint'(wscale),
				longint'(ACC_MIN), longint'(ACC_MAX), hit);
			sat_seen  = sat_seen | hit;
			group_sum = 0;
		end
		if (!re) begin
			return 1'b0;
		end
		v = clip_to(scale_row(row_acc, ascale) + longint'(b),
			longint'(ACC_MIN), longint'(ACC_MAX), clip);
		res.value = v[ACC_W-1:0];
		res.sat   = sat_seen | clip;
		group_sum = 0;
		row_acc   = 0;
		sat_seen  = 1'b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("ERROR row %0d %s: got %0d expected %0d", rows_seen, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		row_result_t want;
		row_result_t fresh;
		if (!arst_n) begin
			packed_mode  = 1'b0;
			group_sum    = 0;
			row_acc      = 0;
			sat_seen     = 1'b0;
			rows_seen    = 0;
			mismatches   = 0;
			expected_rows.delete();
			rows_pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rows.size() == 0) begin
					report_mismatch("result with no row pending", longint'(rsp.row_value), 0);
				end else begin
					want = expected_rows.pop_front();
					if (rsp.row_value !== want.value) begin
						report_mismatch("row_value", longint'(rsp.row_value),
							longint'(want.value));
					end
					if (rsp.saturated !== want.sat) begin
						report_mismatch("saturated", longint'(rsp.saturated),
							longint'(want.sat));
					end
				end
				rows_seen++;
			end
			if (cfg_we) begin
				packed_mode = cfg_wdata;
			end
			if (req.valid && req.ready) begin
				if (accumulate_pair(req.weight_pair, req.act_even, req.act_odd,
						req.weight_scale, req.act_scale, req.bias, req.group_end,
						req.row_end, fresh)) begin
					expected_rows.push_back(fresh);
				end
			end
			rows_pending = expected_rows.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the quantized int8/int4 dot product: clock, reset,
// directed and random request stimulus, result back-pressure and verdict.
// Depends on qdot_pkg, qdot_req_if, qdot_rsp_if, qdot_row_checker and the block.

module tb import qdot_pkg::*;;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 12;

	typedef struct packed {
		logic [WPAIR_W-1:0]       weight_pair;
		logic signed [ACT_W-1:0]  act_even;
		logic signed [ACT_W-1:0]  act_odd;
		logic [SCALE_W-1:0]       weight_scale;
		logic [SCALE_W-1:0]       act_scale;
		logic signed [BIAS_W-1:0] bias;
		logic                     group_end;
		logic                     row_end;
	} pair_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   mismatches;
	int   rows_pending;
	bit   req_steady;

	qdot_req_if req_ch ();
	qdot_rsp_if rsp_ch ();

	quantized_int8_int4_dot_product dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	qdot_row_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.mismatches   (mismatches),
		.rows_pending (rows_pending)
	);

	always #5 clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	function automatic logic signed [ACT_W-1:0] pick_act();
		if ($urandom_range(0, 99) < 6) begin
			return -8'sd128;
		end
		return 8'($urandom_range(0, 254) - 127);
	endfunction

	function automatic logic [SCALE_W-1:0] pick_scale();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return '0;
		end
		if (r < 16) begin
			return '1;
		end
		if (r < 45) begin
			return 24'($urandom_range(0, 24'h1FFFFF));
		end
		return 24'($urandom);
	endfunction

	function automatic pair_t make_pair(input logic [15:0] wp, input int ae, input int ao,
			input logic [23:0] wscale, input logic [23:0] ascale, input logic [31:0] b,
			input bit ge, input bit re);
		pair_t p;
		p.weight_pair  = wp;
		p.act_even     = 8'(ae);
		p.act_odd      = 8'(ao);
		p.weight_scale = wscale;
		p.act_scale    = ascale;
		p.bias         = b;
		p.group_end    = ge;
		p.row_end      = re;
		return p;
	endfunction

	task automatic send_pair(input pair_t p);
		int gap;
		gap = req_steady ? 0 : idle_len();
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid        <= 1'b1;
		req_ch.weight_pair  <= p.weight_pair;
		req_ch.act_even     <= p.act_even;
		req_ch.act_odd      <= p.act_odd;
		req_ch.weight_scale <= p.weight_scale;
		req_ch.act_scale    <= p.act_scale;
		req_ch.bias         <= p.bias;
		req_ch.group_end    <= p.group_end;
		req_ch.row_end      <= p.row_end;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (rows_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_mode(input logic m);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_row(input logic packed_mode, output int len);
		int    r;
		bit    hot;
		bit    neg;
		pair_t p;
		r   = $urandom_range(0, 99);
		len = (r < 70) ? $urandom_range(1, 8) :
			(r < 93) ? $urandom_range(9, 40) : $urandom_range(100, 300);
		hot = ($urandom_range(0, 4) == 0);
		neg = $urandom_range(0, 1);
		req_steady = ($urandom_range(0, 5) == 0);
		for (int i = 0; i < len; i++) begin
			p.weight_pair  = 16'($urandom);
			p.act_even     = pick_act();
			p.act_odd      = pick_act();
			p.weight_scale = pick_scale();
			p.act_scale    = pick_scale();
			p.bias         = 32'($urandom);
			p.group_end    = ($urandom_range(0, 3) == 0);
			p.row_end      = (i == len - 1);
			if (hot) begin
				p.weight_pair  = packed_mode ? {p.weight_pair[15:8], 8'h00} : 16'h8080;
				p.act_even     = neg ? 8'sd127 : -8'sd128;
				p.act_odd      = p.act_even;
				p.weight_scale = '1;
			end
			send_pair(p);
		end
	endtask

	initial begin
		int sent;
		int len;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = 1'b0;
		req_steady          = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.weight_pair  = '0;
		req_ch.act_even     = '0;
		req_ch.act_odd      = '0;
		req_ch.weight_scale = '0;
		req_ch.act_scale    = '0;
		req_ch.bias         = '0;
		req_ch.group_end    = 1'b0;
		req_ch.row_end      = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Int8 weights: extremes, ignored group marks, zero scales and rounding ties.
		set_mode(1'b0);
		send_pair(make_pair(16'h8080, -128, -128, '1, '1, 32'h7FFFFFFF, 1, 1));
		send_pair(make_pair(16'h7F80, 127, -127, '0, '0, 32'h80000000, 0, 1));
		send_pair(make_pair(16'h7F7F, -127, -127, 24'h123456, 24'h100000, 0, 1, 0));
		send_pair(make_pair(16'h0180, 5, -3, 24'h000001, 24'h100000, 32'hFFFFFFFF, 0, 1));
		send_pair(make_pair(16'h0001, 1, 0, 24'h000001, 24'h080000, 0, 0, 1));
		send_pair(make_pair(16'h0001, -1, 0, 24'h000001, 24'h080000, 0, 0, 1));
		for (int i = 0; i < 16; i++) begin
			send_pair(make_pair(16'h8080, -128, -128, '1, '1, 32'h7FFFFFFF, 0, i == 15));
		end

		// Packed int4 weights: nibble extremes, group closes and a row end without one.
		wait_idle();
		set_mode(1'b1);
		send_pair(make_pair(16'h5A0F, 127, -128, 24'h100000, 24'h100000, 0, 1, 0));
		send_pair(make_pair(16'hFFF0, -127, 127, '1, '0, 0, 0, 0));
		send_pair(make_pair(16'h00F0, 100, -100, 24'h0ABCDE, 24'h0FFFFF, 32'h1234, 0, 1));
		send_pair(make_pair(16'h3C88, -128, 127, '1, '1, 32'h80000000, 1, 1));

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			set_mode(ph % 2);
			sent = 0;
			while (sent < 150) begin
				random_row(ph % 2, len);
				sent += len;
			end
		end

		// One long row whose single group clips the accumulator at the row end.
		wait_idle();
		set_mode(1'b0);
		req_steady = 1'b0;
		for (int i = 0; i < 280; i++) begin
			send_pair(make_pair(16'h8080, -128, -128, '1, pick_scale(),
				32'($urandom), $urandom_range(0, 1), i == 279));
		end

		wait_idle();
		if (mismatches == 0 && rows_pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		int stall;
		int hold;
		rsp_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			stall = idle_len();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
			repeat (hold) @(negedge clk);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== quantized_int8_int4_dot_product.f =====
rtl/core/qdot_pkg.sv
rtl/core/qdot_req_if.sv
rtl/core/qdot_rsp_if.sv
rtl/core/qdot_mul.sv
rtl/core/quantized_int8_int4_dot_product.sv
rtl/core/qdot_chk.sv
dv/qdot_row_checker.sv
dv/tb.sv
